>>> design/rgpc_pkg.sv
// Shared types, constants and arithmetic helpers for the ray ground point classifier.
`timescale 1ns / 1ps

package rgpc_pkg;

  // Width of the point index carried through the block.
  localparam int INDEX_BITS = 17;

  // Field widths fixed by the point format.
  localparam int RADIUS_W = 18;
  localparam int HEIGHT_W = 16;
  localparam int TAN_W    = 16;
  localparam int SVAL_W   = 20;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_SLOPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GENERAL_SLOPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONCENTRIC     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECLASS        = 3'd5;

  // Reset values of the registers.
  localparam logic [12:0] SENSOR_HEIGHT_RST = 13'd1780;
  localparam logic [15:0] LOCAL_SLOPE_RST   = 16'd5759;
  localparam logic [15:0] GENERAL_SLOPE_RST = 16'd5759;
  localparam logic [11:0] MIN_THRESHOLD_RST = 12'd50;
  localparam logic [15:0] CONCENTRIC_RST    = 16'd10;
  localparam logic [15:0] RECLASS_RST       = 16'd200;

  // Previous height after reset is minus the reset sensor height.
  localparam logic signed [HEIGHT_W-1:0] LAST_HEIGHT_RST = -16'sd1780;

  // Signed working value wide enough for every band edge.
  typedef logic signed [SVAL_W-1:0] sval_t;

  typedef struct packed {
    logic [12:0] sensor_height_mm;
    logic [15:0] local_slope_tan;
    logic [15:0] general_slope_tan;
    logic [11:0] min_height_threshold_mm;
    logic [15:0] concentric_distance_mm;
    logic [15:0] reclass_distance_mm;
  } cfg_t;

  // What the previous point of the ray left behind.
  typedef struct packed {
    logic [RADIUS_W-1:0]        radius;
    logic signed [HEIGHT_W-1:0] height;
    logic                       ground;
  } prev_t;

  // Tangent times distance magnitude, shifted down by 16, saturated at 65535.
  function automatic logic [15:0] sat_scale(input logic [TAN_W-1:0] tan_q16,
                                            input logic [RADIUS_W-1:0] mag);
    logic [TAN_W+RADIUS_W-1:0] prod;
    prod = {{RADIUS_W{1'b0}}, tan_q16} * {{TAN_W{1'b0}}, mag};
    if (|prod[TAN_W+RADIUS_W-1:32]) begin
      return 16'hFFFF;
    end
    return prod[31:16];
  endfunction

  // True when h lies within centre - t .. centre + t.
  function automatic logic in_band(input sval_t h, input sval_t centre, input sval_t t);
    return (h <= centre + t) && (h >= centre - t);
  endfunction

endpackage

>>> design/ray_ground_point_classifier.sv
// Top level of the ray ground point classifier: input stage, decision stage and result register.
`timescale 1ns / 1ps

// The block takes the points of one LiDAR ray in ascending radius order and
// answers each with its index and a ground mark, one result per point in
// arrival order. It accepts one point in every clock cycle while the result
// output is not stalled. A point is held in an input register after its
// transfer; a single decision stage then compares it with the state left by
// the previous point (radius, height, ground mark) and, once the result
// register is free, writes both the result register and that state. The
// sustained rate of one point a cycle rests on this loop through the state.
// A point with the ray start flag is judged as if the previous point sat at
// radius zero at minus the sensor height and was not ground. Registers are
// written through the configuration port, which is always ready; writes
// should only be made while no point is in flight. Indexes beyond the
// register list are ignored.

module ray_ground_point_classifier
  import rgpc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // Point input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [RADIUS_W-1:0]        in_radius_mm,
  input  logic signed [HEIGHT_W-1:0] in_height_mm,
  input  logic [INDEX_BITS-1:0]      in_point_index,
  input  logic                       in_ray_start,
  // Result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [INDEX_BITS-1:0]      out_index,
  output logic                       out_is_ground,
  // Configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  cfg_t cfg;

  // Input stage.
  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic [RADIUS_W-1:0]        s1_radius_r;
  logic signed [HEIGHT_W-1:0] s1_height_r;
  logic [INDEX_BITS-1:0]      s1_index_r;
  logic                       s1_start_r;

  // Result register.
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [INDEX_BITS-1:0]      out_index_r;
  logic                       out_ground_r;

  // State left by the previous point.
  prev_t                      last_r;
  prev_t                      last_nxt;

  logic                       in_xfer;
  logic                       out_free;
  logic                       s1_adv;
  logic                       ground;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  rgpc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register can take a new result when it is empty or being
  // drained in this cycle, so the input stage keeps flowing under a full output that is being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !out_free);
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  rgpc_classify u_classify (
    .cfg       (cfg),
    .last      (last_r),
    .radius_mm (s1_radius_r),
    .height_mm (s1_height_r),
    .ray_start (s1_start_r),
    .is_ground (ground)
  );

  // The judged point becomes the reference for the next one.
  always_comb begin
    last_nxt = last_r;
    if (s1_adv) begin
      last_nxt.radius = s1_radius_r;
      last_nxt.height = s1_height_r;
      last_nxt.ground = ground;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_r.radius <= '0;
      last_r.height <= LAST_HEIGHT_RST;
      last_r.ground <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_radius_r <= in_radius_mm;
      s1_height_r <= in_height_mm;
      s1_index_r  <= in_point_index;
      s1_start_r  <= in_ray_start;
    end
    if (s1_adv) begin
      out_index_r  <= s1_index_r;
      out_ground_r <= ground;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_is_ground = out_ground_r;

  // The input stage only stalls behind a full, stalled result register.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid_r))
    else $error("input stalled without a blocked result");

  // A point leaving the input stage always shows up as a result.
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_valid_r && out_index_r == $past(s1_index_r)))
    else $error("result register missed a point");

  // The state tracks the last judged point.
  a_state_update : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (last_r.radius == $past(s1_radius_r) &&
                last_r.ground == out_ground_r))
    else $error("previous point state not updated");

  // Without a transfer out of the input stage the state holds.
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(last_r))
    else $error("previous point state changed without a point");

endmodule

>>> design/rgpc_cfg_regs.sv
// Configuration register file of the ray ground point classifier.
`timescale 1ns / 1ps

module rgpc_cfg_regs
  import rgpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_SENSOR_HEIGHT: cfg_nxt.sensor_height_mm        = wr_data[12:0];
        REG_LOCAL_SLOPE:   cfg_nxt.local_slope_tan         = wr_data;
        REG_GENERAL_SLOPE: cfg_nxt.general_slope_tan       = wr_data;
        REG_MIN_THRESHOLD: cfg_nxt.min_height_threshold_mm = wr_data[11:0];
        REG_CONCENTRIC:    cfg_nxt.concentric_distance_mm  = wr_data;
        REG_RECLASS:       cfg_nxt.reclass_distance_mm     = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_height_mm        <= SENSOR_HEIGHT_RST;
      cfg_r.local_slope_tan         <= LOCAL_SLOPE_RST;
      cfg_r.general_slope_tan       <= GENERAL_SLOPE_RST;
      cfg_r.min_height_threshold_mm <= MIN_THRESHOLD_RST;
      cfg_r.concentric_distance_mm  <= CONCENTRIC_RST;
      cfg_r.reclass_distance_mm     <= RECLASS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/rgpc_classify.sv
// Combinational ground decision for one point against the previous point of its ray.
`timescale 1ns / 1ps

module rgpc_classify
  import rgpc_pkg::*;
(
  input  cfg_t                       cfg,
  input  prev_t                      last,
  input  logic [RADIUS_W-1:0]        radius_mm,
  input  logic signed [HEIGHT_W-1:0] height_mm,
  input  logic                       ray_start,
  output logic                       is_ground
);

  logic [RADIUS_W-1:0]        ref_radius;
  logic signed [HEIGHT_W-1:0] ref_height;
  logic                       ref_ground;
  sval_t                      base;
  sval_t                      h;
  sval_t                      gap;
  sval_t                      gap_neg_val;
  logic                       gap_neg;
  logic [RADIUS_W-1:0]        gap_mag;
  logic [15:0]                p_local;
  logic [15:0]                p_general;
  sval_t                      t_local_raw;
  sval_t                      t_local;
  sval_t                      t_general;
  logic                       near_prev;

  always_comb begin
    // A new ray starts from radius zero on the sensor's ground plane.
    base       = -sval_t'({{(SVAL_W-13){1'b0}}, cfg.sensor_height_mm});
    ref_radius = ray_start ? '0 : last.radius;
    ref_height = ray_start ? base[HEIGHT_W-1:0] : last.height;
    ref_ground = ray_start ? 1'b0 : last.ground;

    h           = sval_t'(height_mm);
    gap         = sval_t'({2'b00, radius_mm}) - sval_t'({2'b00, ref_radius});
    gap_neg     = gap[SVAL_W-1];
    gap_neg_val = -gap;
    gap_mag     = gap_neg ? gap_neg_val[RADIUS_W-1:0] : gap[RADIUS_W-1:0];

    p_local     = sat_scale(cfg.local_slope_tan, gap_mag);
    p_general   = sat_scale(cfg.general_slope_tan, radius_mm);

    // The local threshold carries the sign of the gap.
    t_local_raw = sval_t'({4'd0, p_local});
    if (gap_neg) begin
      t_local_raw = -sval_t'({4'd0, p_local});
    end
    t_general   = sval_t'({4'd0, p_general});

    // Wide gaps get at least the minimum threshold.
    t_local = t_local_raw;
    if ((gap > sval_t'({4'd0, cfg.concentric_distance_mm})) &&
        (t_local_raw < sval_t'({8'd0, cfg.min_height_threshold_mm}))) begin
      t_local = sval_t'({8'd0, cfg.min_height_threshold_mm});
    end

    near_prev = in_band(h, sval_t'(ref_height), t_local);
    if (near_prev) begin
      is_ground = ref_ground || in_band(h, base, t_general);
    end else begin
      is_ground = (gap > sval_t'({4'd0, cfg.reclass_distance_mm})) &&
                  in_band(h, base, t_local);
    end
  end

endmodule
